### hdl/cfr_pkg.sv
// Shared types and constants of the clock frame replacement block.
package cfr_pkg;

    localparam int SLOTS    = 64;
    localparam int TAG_BITS = 20;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic                sc;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP_RD,
        ST_SWEEP_EV,
        ST_CMP_RD,
        ST_CMP_EV,
        ST_APPEND,
        ST_DONE
    } t_state;

endpackage

### hdl/cfr_req_if.sv
// Request channel: operation code and page tag.
interface cfr_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [cfr_pkg::TAG_BITS-1:0] page_tag;

    modport source (output valid, func, page_tag, input ready);
    modport sink   (input valid, func, page_tag, output ready);
endinterface

### hdl/cfr_rsp_if.sv
// Response channel: eviction report and release hit flag.
interface cfr_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         evicted;
    logic [cfr_pkg::TAG_BITS-1:0] victim_tag;
    logic                         found;

    modport source (output valid, evicted, victim_tag, found, input ready);
    modport sink   (input valid, evicted, victim_tag, found, output ready);
endinterface

### hdl/cfr_ram.sv
// Generic simple dual-port RAM with registered read data.
module cfr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 21,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/clock_frame_replacement_core.sv
// Clock (second-chance) frame replacement: item sequencer around the frame table RAM.
//
// The frame table lives in one RAM with a single write and a single registered read
// port; every table step is a read, then an evaluate and write back. Allocate with
// room appends. Allocate on a full table sweeps from the hand, clearing set reference
// bits, evicts the first clear entry, compacts the entries after it and appends.
// Release compacts the table. The request side is ready only between items; a finished
// response waits in an output register, so the next request may enter meanwhile.
// Capacity register: 0 acts as 1, values above the table size act as the table size.
module clock_frame_replacement_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cfr_pkg::CFG_W-1:0] i_cfg_wdata,
    cfr_req_if.sink                   i_req,
    cfr_rsp_if.source                 o_rsp
);

    localparam int IW = cfr_pkg::IDX_W;
    localparam int CW = cfr_pkg::CNT_W;
    localparam int TW = cfr_pkg::TAG_BITS;

    cfr_pkg::t_state r_state, n_state;

    logic                      r_func;
    logic [TW-1:0]             r_tag;
    logic [CW-1:0]             r_count, n_count;
    logic [IW-1:0]             r_hand, n_hand;
    logic [IW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_rd, n_rd;
    logic [CW-1:0]             r_wr, n_wr;
    logic                      r_found, n_found;
    logic                      r_evicted, n_evicted;
    logic [TW-1:0]             r_victim, n_victim;
    logic [cfr_pkg::CFG_W-1:0] r_cfg;

    logic          r_out_valid;
    logic          r_out_evicted;
    logic [TW-1:0] r_out_victim;
    logic          r_out_found;

    logic             req_acc;
    logic             out_load;
    logic [CW-1:0]    cap;
    logic             full;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    cfr_pkg::t_entry  ram_wdata;
    logic [IW-1:0]    ram_raddr;
    cfr_pkg::t_entry  ram_q;
    logic [$bits(cfr_pkg::t_entry)-1:0] ram_rdata;
    logic             rd_end;
    logic             tag_hit;

    cfr_ram #(
        .DEPTH (cfr_pkg::SLOTS),
        .WIDTH ($bits(cfr_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_q = cfr_pkg::t_entry'(ram_rdata);

    always_comb begin
        if (r_cfg == '0) begin
            cap = CW'(1);
        end else if (int'(r_cfg) > cfr_pkg::SLOTS) begin
            cap = CW'(cfr_pkg::SLOTS);
        end else begin
            cap = CW'(r_cfg);
        end
    end

    assign full    = (r_count >= cap) && (r_count != '0);
    assign req_acc = i_req.valid && i_req.ready;
    assign rd_end  = (r_rd >= r_count);
    assign tag_hit = (ram_q.tag == r_tag);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfr_pkg::ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.func == cfr_pkg::FUNC_RELEASE) begin
                        n_state = cfr_pkg::ST_CMP_RD;
                    end else if (full) begin
                        n_state = cfr_pkg::ST_SWEEP_RD;
                    end else begin
                        n_state = cfr_pkg::ST_APPEND;
                    end
                end
            end
            cfr_pkg::ST_SWEEP_RD: n_state = cfr_pkg::ST_SWEEP_EV;
            cfr_pkg::ST_SWEEP_EV: begin
                n_state = ram_q.sc ? cfr_pkg::ST_SWEEP_RD : cfr_pkg::ST_CMP_RD;
            end
            cfr_pkg::ST_CMP_RD: begin
                if (!rd_end) begin
                    n_state = cfr_pkg::ST_CMP_EV;
                end else if (r_func == cfr_pkg::FUNC_ALLOC) begin
                    n_state = cfr_pkg::ST_APPEND;
                end else begin
                    n_state = cfr_pkg::ST_DONE;
                end
            end
            cfr_pkg::ST_CMP_EV: n_state = cfr_pkg::ST_CMP_RD;
            cfr_pkg::ST_APPEND: n_state = cfr_pkg::ST_DONE;
            cfr_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = cfr_pkg::ST_IDLE;
                end
            end
            default: n_state = cfr_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_count   = r_count;
        n_hand    = r_hand;
        n_pos     = r_pos;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_found   = r_found;
        n_evicted = r_evicted;
        n_victim  = r_victim;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = ram_q;
        ram_raddr = r_pos;
        out_load  = 1'b0;
        i_req.ready = 1'b0;
        unique case (r_state)
            cfr_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                n_evicted = 1'b0;
                n_victim  = '0;
                n_found   = (i_req.func == cfr_pkg::FUNC_ALLOC);
                n_rd      = '0;
                n_wr      = '0;
                n_pos     = (CW'(r_hand) < r_count) ? r_hand : '0;
            end
            cfr_pkg::ST_SWEEP_RD: begin
                ram_raddr = r_pos;
            end
            cfr_pkg::ST_SWEEP_EV: begin
                if (ram_q.sc) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_pos;
                    ram_wdata.sc = 1'b0;
                    n_pos = (CW'(r_pos) + CW'(1) < r_count) ? r_pos + IW'(1) : '0;
                end else begin
                    n_evicted = 1'b1;
                    n_victim  = ram_q.tag;
                    n_wr      = CW'(r_pos);
                    n_rd      = CW'(r_pos) + CW'(1);
                end
            end
            cfr_pkg::ST_CMP_RD: begin
                ram_raddr = r_rd[IW-1:0];
                if (rd_end) begin
                    n_count = r_wr;
                    if (r_func == cfr_pkg::FUNC_ALLOC) begin
                        n_hand = (CW'(r_pos) < r_wr) ? r_pos : '0;
                    end else if (CW'(r_hand) >= r_wr) begin
                        n_hand = '0;
                    end
                end
            end
            cfr_pkg::ST_CMP_EV: begin
                n_rd = r_rd + CW'(1);
                if (r_func == cfr_pkg::FUNC_RELEASE && tag_hit) begin
                    n_found = 1'b1;
                    if (r_wr < CW'(r_hand)) begin
                        n_hand = r_hand - IW'(1);
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr[IW-1:0];
                    ram_wdata = ram_q;
                    n_wr      = r_wr + CW'(1);
                end
            end
            cfr_pkg::ST_APPEND: begin
                if (int'(r_count) < cfr_pkg::SLOTS) begin
                    ram_we        = 1'b1;
                    ram_waddr     = r_count[IW-1:0];
                    ram_wdata.sc  = 1'b1;
                    ram_wdata.tag = r_tag;
                    n_count       = r_count + CW'(1);
                end
            end
            cfr_pkg::ST_DONE: begin
                out_load = !r_out_valid || o_rsp.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfr_pkg::ST_IDLE;
            r_count     <= '0;
            r_hand      <= '0;
            r_cfg       <= cfr_pkg::CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hand  <= n_hand;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_func <= i_req.func;
            r_tag  <= i_req.page_tag;
        end
        r_pos     <= n_pos;
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_found   <= n_found;
        r_evicted <= n_evicted;
        r_victim  <= n_victim;
        if (out_load) begin
            r_out_evicted <= r_evicted;
            r_out_victim  <= r_victim;
            r_out_found   <= r_found;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.evicted    = r_out_evicted;
    assign o_rsp.victim_tag = r_out_victim;
    assign o_rsp.found      = r_out_found;

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= cfr_pkg::SLOTS)
        else $error("entry count above table size");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cfr_pkg::ST_IDLE |-> (r_hand == '0 || CW'(r_hand) < r_count))
        else $error("hand outside occupied entries");

    a_evict_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.evicted |-> o_rsp.found)
        else $error("eviction reported without found");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.evicted |-> o_rsp.victim_tag == '0)
        else $error("victim tag set without eviction");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cfr_pkg::ST_APPEND |=> r_count != '0)
        else $error("append left table empty");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the clock frame replacement core: directed rows, then random phases.
module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 168;
    localparam int NUM_PHASES     = 10;
    localparam int DIRECTED_ROWS  = 23;
    localparam int CAP_RANDOM     = -1;

    typedef struct packed {
        logic                         evicted;
        logic [cfr_pkg::TAG_BITS-1:0] victim;
        logic                         found;
    } t_report;

    typedef struct packed {
        logic                         func;
        logic [cfr_pkg::TAG_BITS-1:0] tag;
        logic                         typed;
        logic                         evicted;
        logic [cfr_pkg::TAG_BITS-1:0] victim;
        logic                         found;
    } t_stim_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_NOISY,
        RX_PERIODIC
    } t_stall_mode;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [cfr_pkg::CFG_W-1:0] i_cfg_wdata;
    logic                      sink_ready = 1'b0;

    cfr_req_if req_bus();
    cfr_rsp_if rsp_bus();

    assign rsp_bus.ready = sink_ready;

    clock_frame_replacement_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    // frame table mirror
    logic [cfr_pkg::TAG_BITS-1:0] ft_tag[$];
    bit                           ft_sc[$];
    int                           ft_hand   = 0;
    logic [cfr_pkg::CFG_W-1:0]    ft_frames = cfr_pkg::CFG_RESET;

    t_report expected_reports[$];

    int          mismatches     = 0;
    int          reports_seen   = 0;
    int          items_sent     = 0;
    int          releases_sent  = 0;
    int          evictions_seen = 0;
    int          settings_done  = 0;
    int          burst_left     = 0;
    bit          gaps_on        = 1'b0;
    t_stall_mode rx_mode        = RX_OPEN;
    logic [15:0] rx_lfsr        = 16'hACE1;
    int          rx_tick        = 0;
    int          stall_cycles   = 0;

    int phase_caps [NUM_PHASES] = '{1, 0, 5, 64, 127, 3, 16, CAP_RANDOM, 64, 2};

    t_stim_row directed [DIRECTED_ROWS] = '{
        '{cfr_pkg::FUNC_RELEASE, 20'h00000, 1'b1, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_ALLOC,   20'hFFFFF, 1'b1, 1'b0, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_ALLOC,   20'h00000, 1'b1, 1'b0, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_ALLOC,   20'h12345, 1'b1, 1'b0, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_ALLOC,   20'hABCDE, 1'b1, 1'b1, 20'hFFFFF, 1'b1},
        '{cfr_pkg::FUNC_ALLOC,   20'h00001, 1'b1, 1'b1, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_RELEASE, 20'h12345, 1'b1, 1'b0, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_ALLOC,   20'hABCDE, 1'b1, 1'b0, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_RELEASE, 20'hABCDE, 1'b1, 1'b0, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_RELEASE, 20'hABCDE, 1'b1, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_ALLOC,   20'h80000, 1'b1, 1'b0, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_ALLOC,   20'h7FFFF, 1'b1, 1'b0, 20'h00000, 1'b1},
        '{cfr_pkg::FUNC_ALLOC,   20'h55555, 1'b1, 1'b1, 20'h00001, 1'b1},
        '{cfr_pkg::FUNC_ALLOC,   20'h2AAAA, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_RELEASE, 20'h7FFFF, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_ALLOC,   20'h33333, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_ALLOC,   20'h44444, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_RELEASE, 20'h55555, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_ALLOC,   20'h66666, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_ALLOC,   20'h77777, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_RELEASE, 20'h2AAAA, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_ALLOC,   20'h11111, 1'b0, 1'b0, 20'h00000, 1'b0},
        '{cfr_pkg::FUNC_RELEASE, 20'h12345, 1'b0, 1'b0, 20'h00000, 1'b0}
    };

    function automatic t_report predict_frame_op(input logic func,
                                                 input logic [cfr_pkg::TAG_BITS-1:0] tag);
        t_report rep;
        int      cap;
        int      pos;
        int      guard;
        int      i;
        rep = '{evicted: 1'b0, victim: '0, found: 1'b1};
        if (func == cfr_pkg::FUNC_ALLOC) begin
            cap = (ft_frames == 0) ? 1 :
                  ((int'(ft_frames) > cfr_pkg::SLOTS) ? cfr_pkg::SLOTS : int'(ft_frames));
            if (ft_tag.size() >= cap && ft_tag.size() > 0) begin
                pos   = (ft_hand < ft_tag.size()) ? ft_hand : 0;
                guard = 2 * ft_tag.size() + 1;
                while (ft_sc[pos] && guard > 0) begin
                    ft_sc[pos] = 1'b0;
                    pos        = (pos + 1 < ft_tag.size()) ? pos + 1 : 0;
                    guard--;
                end
                rep.evicted = 1'b1;
                rep.victim  = ft_tag[pos];
                ft_tag.delete(pos);
                ft_sc.delete(pos);
                ft_hand = (pos < ft_tag.size()) ? pos : 0;
            end
            if (ft_tag.size() < cfr_pkg::SLOTS) begin
                ft_tag.push_back(tag);
                ft_sc.push_back(1'b1);
            end
        end else begin
            rep.found = 1'b0;
            i = 0;
            while (i < ft_tag.size()) begin
                if (ft_tag[i] == tag) begin
                    rep.found = 1'b1;
                    if (i < ft_hand) ft_hand--;
                    ft_tag.delete(i);
                    ft_sc.delete(i);
                end else begin
                    i++;
                end
            end
            if (ft_hand >= ft_tag.size()) ft_hand = 0;
        end
        return rep;
    endfunction

    task automatic push_item(input logic func, input logic [cfr_pkg::TAG_BITS-1:0] tag,
                             input logic typed, input t_report typed_rep);
        t_report predicted;
        int      gap;
        req_bus.valid    <= 1'b1;
        req_bus.func     <= func;
        req_bus.page_tag <= tag;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        predicted = predict_frame_op(func, tag);
        expected_reports.push_back(typed ? typed_rep : predicted);
        items_sent++;
        if (func == cfr_pkg::FUNC_RELEASE) releases_sent++;
        if (predicted.evicted) evictions_seen++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap        = gaps_on ? $urandom_range(1, 30) : 0;
            if (gap > 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic set_frames(input logic [cfr_pkg::CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        ft_frames = value;
        settings_done++;
    endtask

    task automatic drain_reports();
        req_bus.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    // response side back-pressure
    always @(posedge i_clk) begin
        rx_lfsr <= {rx_lfsr[14:0], rx_lfsr[15] ^ rx_lfsr[13] ^ rx_lfsr[12] ^ rx_lfsr[10]};
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_OPEN:     sink_ready <= 1'b1;
            RX_NOISY:    sink_ready <= rx_lfsr[0] | rx_lfsr[3];
            RX_PERIODIC: sink_ready <= (rx_tick % 13) >= 8;
            default:     sink_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin : report_check
        t_report want;
        if (i_rst_n && rsp_bus.valid && sink_ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report: evicted %0b victim %05h found %0b",
                         $time, rsp_bus.evicted, rsp_bus.victim_tag, rsp_bus.found);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                if (rsp_bus.evicted !== want.evicted) begin
                    $display("%0t: evicted mismatch: expected %0b actual %0b",
                             $time, want.evicted, rsp_bus.evicted);
                    mismatches++;
                end
                if (rsp_bus.victim_tag !== want.victim) begin
                    $display("%0t: victim_tag mismatch: expected %05h actual %05h",
                             $time, want.victim, rsp_bus.victim_tag);
                    mismatches++;
                end
                if (rsp_bus.found !== want.found) begin
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $time, want.found, rsp_bus.found);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && sink_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d reports outstanding",
                     $time, stall_cycles, expected_reports.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int                           ph;
        int                           k;
        int                           cap;
        int                           alloc_pct;
        int                           roll;
        logic                         func;
        logic [cfr_pkg::TAG_BITS-1:0] tag;
        t_report                      row_rep;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        req_bus.valid    <= 1'b0;
        req_bus.func     <= cfr_pkg::FUNC_ALLOC;
        req_bus.page_tag <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_frames(7'd3);
        for (k = 0; k < DIRECTED_ROWS; k++) begin
            row_rep = '{directed[k].evicted, directed[k].victim, directed[k].found};
            push_item(directed[k].func, directed[k].tag, directed[k].typed, row_rep);
        end
        drain_reports();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            cap = (phase_caps[ph] == CAP_RANDOM) ? $urandom_range(0, 127) : phase_caps[ph];
            set_frames(cap[cfr_pkg::CFG_W-1:0]);
            gaps_on   = ph[0];
            rx_mode   = t_stall_mode'(ph % 3);
            alloc_pct = (cap >= 64) ? 75 : 55;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < alloc_pct) begin
                    func = cfr_pkg::FUNC_ALLOC;
                    roll = $urandom_range(0, 99);
                    if (roll < 15 && ft_tag.size() > 0)
                        tag = ft_tag[$urandom_range(0, ft_tag.size() - 1)];
                    else if (roll < 45)
                        tag = cfr_pkg::TAG_BITS'($urandom_range(0, 31));
                    else if (roll < 50)
                        tag = $urandom_range(0, 1) ? '1 : '0;
                    else
                        tag = cfr_pkg::TAG_BITS'($urandom());
                end else begin
                    func = cfr_pkg::FUNC_RELEASE;
                    if ($urandom_range(0, 99) < 80 && ft_tag.size() > 0)
                        tag = ft_tag[$urandom_range(0, ft_tag.size() - 1)];
                    else
                        tag = cfr_pkg::TAG_BITS'($urandom());
                end
                push_item(func, tag, 1'b0, '0);
            end
            drain_reports();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Drove %0d requests (%0d releases) over %0d capacity settings.",
                 items_sent, releases_sent, settings_done);
        $display("Checked %0d reports, %0d with an eviction; %0d field mismatches.",
                 reports_seen, evictions_seen, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### clock_frame_replacement_core.f
hdl/cfr_pkg.sv
hdl/cfr_req_if.sv
hdl/cfr_rsp_if.sv
hdl/cfr_ram.sv
hdl/clock_frame_replacement_core.sv
tb/sv/testbench.sv
